>>> rtl/core/particle_euler_step_with_drag_assert.svh
// Assertion macros for the particle update block.
`ifndef PARTICLE_EULER_STEP_WITH_DRAG_ASSERT_SVH
`define PARTICLE_EULER_STEP_WITH_DRAG_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define PES_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// Condition in one cycle that implies another condition in the next cycle.
`define PES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PES_ASSERT(lbl, cond, msg)
`define PES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/pes_pkg.sv
package pes_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STEP_TIME     = 2'd0;
   localparam logic [1:0] CSR_DRAG_COEF     = 2'd1;
   localparam logic [1:0] CSR_GRAVITY_ACCEL = 2'd2;

   // Register reset values.
   localparam logic [19:0] STEP_TIME_RESET     = 20'd1092;
   localparam logic [15:0] DRAG_COEF_RESET     = 16'd3277;
   localparam logic [21:0] GRAVITY_ACCEL_RESET = 22'd642253;

   // Q16.16 one, as the largest drag factor.
   localparam logic [35:0] ONE_Q16 = 36'd65536;

   // Square root: 32 result bits, produced a few per pipeline stage.
   localparam int SQRT_BITS  = 32;
   localparam int SQRT_STEPS = 4;
   localparam int SQRT_STAGES = SQRT_BITS / SQRT_STEPS;

   // Payload that rides along the pipeline unchanged.
   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [25:0]      dvy;
      logic             expired;
   } carry_type;

   // Running state of the digit-by-digit square root.
   typedef struct packed {
      logic [34:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } sqrt_type;

   // Saturate a signed value to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [39:0] v);
      logic [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/core/pes_sqrt_stage.sv
module pes_sqrt_stage import pes_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      valid_in,
   input  sqrt_type  sq_in,
   input  carry_type cr_in,
   output logic      valid_out,
   output sqrt_type  sq_out,
   output carry_type cr_out
);

   logic      valid_ff;
   sqrt_type  sq_ff;
   sqrt_type  sq_in_w;
   carry_type cr_ff;
   logic [34:0] rem_t;
   logic [34:0] trial;

   // A few restoring square root steps, two radicand bits each.
   always_comb begin
      sq_in_w = sq_in;
      rem_t   = '0;
      trial   = '0;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         rem_t = {sq_in_w.rem[32:0], sq_in_w.rad[63:62]};
         trial = {1'b0, sq_in_w.root, 2'b01};
         if (rem_t >= trial) begin
            sq_in_w.rem  = rem_t - trial;
            sq_in_w.root = {sq_in_w.root[30:0], 1'b1};
         end else begin
            sq_in_w.rem  = rem_t;
            sq_in_w.root = {sq_in_w.root[30:0], 1'b0};
         end
         sq_in_w.rad = {sq_in_w.rad[61:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         sq_ff <= sq_in_w;
         cr_ff <= cr_in;
      end
   end

   assign valid_out = valid_ff;
   assign sq_out    = sq_ff;
   assign cr_out    = cr_ff;

endmodule

>>> rtl/core/particle_euler_step_with_drag.sv
// Particle update: one explicit Euler step with speed-proportional drag.
// Each item on the req_ channel is one particle (position, velocity, expiry
// time and current time); each item on the rsp_ channel is its update.
// Both channels use valid and stall; an item moves on a clock edge where
// valid is high and stall is low. Every request yields exactly one response,
// in order.
// The pipeline has 14 register stages: products, sums, eight square root
// stages of four result bits each, the drag factor in two multiply stages,
// the velocity scaling, and the output register. One item can enter every
// cycle while req_stall is low; the square root sets the depth. When rsp_stall
// is high, the items behind the output register close up any empty stages and
// req_stall rises only once every stage holds an item. Synchronous reset
// empties the pipeline and returns step_time, drag_coef and gravity_accel to
// their defaults. Configuration is written through csr_write, csr_index and
// csr_wdata; the user must do so only while no item is in flight, unenforced.
`include "particle_euler_step_with_drag_assert.svh"
module particle_euler_step_with_drag import pes_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [21:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [31:0]        req_expire_time,
   input  logic [31:0]        req_now_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_new_pos_x,
   output logic signed [31:0] rsp_new_pos_y,
   output logic signed [31:0] rsp_new_pos_z,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   output logic               rsp_alive
);

   // Configuration registers.
   logic [19:0] step_ff;
   logic [15:0] drag_ff;
   logic [21:0] grav_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_TIME_RESET;
         drag_ff <= DRAG_COEF_RESET;
         grav_ff <= GRAVITY_ACCEL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_STEP_TIME:     step_ff <= csr_wdata[19:0];
            CSR_DRAG_COEF:     drag_ff <= csr_wdata[15:0];
            CSR_GRAVITY_ACCEL: grav_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage advance chain: a stage loads when it is empty or the next one loads.
   logic adv1, adv2, adv11, adv12, adv13, adv14;
   logic [SQRT_STAGES-1:0] q_adv;
   logic [SQRT_STAGES-1:0] q_valid;
   logic s1_valid_ff, s2_valid_ff, s11_valid_ff, s12_valid_ff, s13_valid_ff, s14_valid_ff;

   assign adv14 = !s14_valid_ff || !rsp_stall;
   assign adv13 = !s13_valid_ff || adv14;
   assign adv12 = !s12_valid_ff || adv13;
   assign adv11 = !s11_valid_ff || adv12;
   assign adv2  = !s2_valid_ff  || q_adv[0];
   assign adv1  = !s1_valid_ff  || adv2;
   assign req_stall = !adv1;

   // Stage 1: squares, position step products and the gravity product.
   logic [2:0][31:0] in_vel;
   logic [2:0][31:0] in_pos;
   logic [2:0][63:0] sq_in;
   logic [2:0][52:0] dp_in;
   logic [2:0][63:0] s1_sq_ff;
   logic [2:0][52:0] s1_dp_ff;
   logic [41:0]      s1_gp_ff;
   logic [2:0][31:0] s1_pos_ff;
   logic [2:0][31:0] s1_vel_ff;
   logic             s1_exp_ff;

   assign in_vel = {req_vel_z, req_vel_y, req_vel_x};
   assign in_pos = {req_pos_z, req_pos_y, req_pos_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = 64'($signed(in_vel[i]) * $signed(in_vel[i]));
         dp_in[i] = 53'($signed({{21{in_vel[i][31]}}, in_vel[i]})
                        * $signed({33'd0, step_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= req_valid;
      end
      if (adv1) begin
         s1_sq_ff  <= sq_in;
         s1_dp_ff  <= dp_in;
         s1_gp_ff  <= 42'(grav_ff) * 42'(step_ff);
         s1_pos_ff <= in_pos;
         s1_vel_ff <= in_vel;
         s1_exp_ff <= req_now_time > req_expire_time;
      end
   end

   // Stage 2: rounded position sums (old position if expired), sum of squares and gravity step.
   logic [2:0][52:0] dp_r;
   logic [2:0][39:0] pos_sum;
   logic [41:0]      gp_r;
   carry_type        cr2_in;
   sqrt_type         sq2_in;
   carry_type        s2_cr_ff;
   sqrt_type         s2_sq_ff;

   always_comb begin
      gp_r = s1_gp_ff + 42'd32768;
      for (int i = 0; i < 3; i++) begin
         dp_r[i]    = s1_dp_ff[i] + 53'd32768;
         pos_sum[i] = {{8{s1_pos_ff[i][31]}}, s1_pos_ff[i]}
                      + {{3{dp_r[i][52]}}, dp_r[i][52:16]};
         cr2_in.pos[i] = s1_exp_ff ? s1_pos_ff[i] : sat32(pos_sum[i]);
      end
      cr2_in.vel     = s1_vel_ff;
      cr2_in.dvy     = gp_r[41:16];
      cr2_in.expired = s1_exp_ff;
      sq2_in.rem     = '0;
      sq2_in.root    = '0;
      sq2_in.rad     = s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv2) begin
         s2_cr_ff <= cr2_in;
         s2_sq_ff <= sq2_in;
      end
   end

   // Square root of the sum of squares, a few bits per stage.
   sqrt_type  q_sq [SQRT_STAGES];
   carry_type q_cr [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      if (k == 0) begin : g_first
         pes_sqrt_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .en        (q_adv[k]),
            .valid_in  (s2_valid_ff),
            .sq_in     (s2_sq_ff),
            .cr_in     (s2_cr_ff),
            .valid_out (q_valid[k]),
            .sq_out    (q_sq[k]),
            .cr_out    (q_cr[k])
         );
      end else begin : g_rest
         pes_sqrt_stage u_stage (
            .clock     (clock),
            .reset     (reset),
            .en        (q_adv[k]),
            .valid_in  (q_valid[k-1]),
            .sq_in     (q_sq[k-1]),
            .cr_in     (q_cr[k-1]),
            .valid_out (q_valid[k]),
            .sq_out    (q_sq[k]),
            .cr_out    (q_cr[k])
         );
      end
      if (k == SQRT_STAGES - 1) begin : g_adv_last
         assign q_adv[k] = !q_valid[k] || adv11;
      end else begin : g_adv
         assign q_adv[k] = !q_valid[k] || q_adv[k+1];
      end
   end

   // Stage 11: speed times drag coefficient.
   logic [47:0] t_prod;
   logic [31:0] s11_t_ff;
   carry_type   s11_cr_ff;

   assign t_prod = 48'(q_sq[SQRT_STAGES-1].root) * 48'(drag_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else if (adv11) begin
         s11_valid_ff <= q_valid[SQRT_STAGES-1];
      end
      if (adv11) begin
         s11_t_ff  <= t_prod[47:16];
         s11_cr_ff <= q_cr[SQRT_STAGES-1];
      end
   end

   // Stage 12: drag factor from the step, clamped to one; velocity scale.
   logic [51:0] fr_prod;
   logic [35:0] fr;
   logic [16:0] scale_in;
   logic [16:0] s12_scale_ff;
   carry_type   s12_cr_ff;

   always_comb begin
      fr_prod  = 52'(s11_t_ff) * 52'(step_ff);
      fr       = fr_prod[51:16];
      scale_in = (fr > ONE_Q16) ? 17'd0 : 17'(ONE_Q16 - fr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s12_valid_ff <= 1'b0;
      end else if (adv12) begin
         s12_valid_ff <= s11_valid_ff;
      end
      if (adv12) begin
         s12_scale_ff <= scale_in;
         s12_cr_ff    <= s11_cr_ff;
      end
   end

   // Stage 13: velocity times scale.
   logic [2:0][49:0] vp_in;
   logic [2:0][49:0] s13_vp_ff;
   carry_type        s13_cr_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vp_in[i] = 50'($signed({{18{s12_cr_ff.vel[i][31]}}, s12_cr_ff.vel[i]})
                        * $signed({33'd0, s12_scale_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_valid_ff <= 1'b0;
      end else if (adv13) begin
         s13_valid_ff <= s12_valid_ff;
      end
      if (adv13) begin
         s13_vp_ff <= vp_in;
         s13_cr_ff <= s12_cr_ff;
      end
   end

   // Stage 14: round, saturate, take gravity off y (expired items keep their velocity); output register.
   logic [2:0][49:0] vp_r;
   logic [2:0][31:0] nv;
   logic [39:0]      vy_grav;
   logic [2:0][31:0] vel_out;
   logic [2:0][31:0] s14_vel_ff;
   logic [2:0][31:0] s14_pos_ff;
   logic             s14_alive_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vp_r[i] = s13_vp_ff[i] + 50'd32768;
         nv[i]   = sat32({{6{vp_r[i][49]}}, vp_r[i][49:16]});
      end
      vy_grav = {{8{nv[1][31]}}, nv[1]} - {14'd0, s13_cr_ff.dvy};
      vel_out[0] = nv[0];
      vel_out[1] = sat32(vy_grav);
      vel_out[2] = nv[2];
      if (s13_cr_ff.expired) begin
         vel_out = s13_cr_ff.vel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s14_valid_ff <= 1'b0;
      end else if (adv14) begin
         s14_valid_ff <= s13_valid_ff;
      end
      if (adv14) begin
         s14_vel_ff   <= vel_out;
         s14_pos_ff   <= s13_cr_ff.pos;
         s14_alive_ff <= !s13_cr_ff.expired;
      end
   end

   assign rsp_valid     = s14_valid_ff;
   assign rsp_new_pos_x = s14_pos_ff[0];
   assign rsp_new_pos_y = s14_pos_ff[1];
   assign rsp_new_pos_z = s14_pos_ff[2];
   assign rsp_new_vel_x = s14_vel_ff[0];
   assign rsp_new_vel_y = s14_vel_ff[1];
   assign rsp_new_vel_z = s14_vel_ff[2];
   assign rsp_alive     = s14_alive_ff;

   // The input is held off only when the whole pipeline is blocked at the output.
   `PES_ASSERT(a_stall_only_when_full, !req_stall || (rsp_valid && rsp_stall), "req_stall without blocked output")
   // The velocity scale never exceeds one.
   `PES_ASSERT(a_scale_range, !s12_valid_ff || (s12_scale_ff <= 17'd65536), "drag scale above one")
   // A step time write lands in the register.
   `PES_ASSERT_NEXT(a_step_write, csr_write && (csr_index == CSR_STEP_TIME), step_ff == $past(csr_wdata[19:0]), "step_time write lost")

endmodule
